// ----- rtl/gfa_pkg.sv -----
// Shared constants and types for the Goldilocks field ALU.
package gfa_pkg;

    localparam int unsigned WordW = 64;
    localparam int unsigned HalfW = 32;
    localparam int unsigned FuncW = 2;
    localparam int unsigned SDataW = 128;
    localparam int unsigned MDataW = 64;

    localparam logic [WordW-1:0] FieldP = 64'hFFFF_FFFF_0000_0001;
    localparam logic [WordW-1:0] FieldEps = 64'h0000_0000_FFFF_FFFF;

    typedef enum logic [FuncW-1:0] {
        FUNC_ADD   = 2'd0,
        FUNC_MUL   = 2'd1,
        FUNC_SQR   = 2'd2,
        FUNC_CANON = 2'd3
    } t_func;

endpackage

// ----- rtl/goldilocks_field_alu.sv -----
// Goldilocks prime field ALU: add, multiply, square and canonicalize mod 2^64-2^32+1.
//
// Input channel (s): tuser carries the operation code (add, multiply, square a,
// canonicalize a), tdata carries operand a in bits 63:0 and operand b in 127:64.
// Output channel (m): tdata carries the 64-bit result, congruent mod p; only
// canonicalize always returns a value below p.
// The datapath is four register stages: partial products and reduction of a,
// product assembly or addition, first fold step, final fold step into the
// output register. o_m_tvalid is the valid bit of that output register, and a
// result is held there until i_m_tready takes it.
// Throughput is one item per cycle while i_m_tready is high, set by the four 32x32
// multipliers in stage one which take a new operand pair whenever stage one advances.
// Each stage advances when it is empty or the stage after it advances, so
// a stall on i_m_tready fills bubbles first; up to four items are held and
// nothing is lost or repeated. o_s_tready drops only when all stages are full
// and the output is stalled.
// Synchronous active-low reset empties the pipeline; payload is not cleared.
module goldilocks_field_alu (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_s_tvalid,
    output logic                       o_s_tready,
    input  logic [gfa_pkg::SDataW-1:0] i_s_tdata,  // operand_a[63:0], operand_b[127:64]
    input  logic [gfa_pkg::FuncW-1:0]  i_s_tuser,  // func[1:0]
    output logic                       o_m_tvalid,
    input  logic                       i_m_tready,
    output logic [gfa_pkg::MDataW-1:0] o_m_tdata   // result[63:0]
);
    import gfa_pkg::*;

    logic en1, en2, en3, en4;

    // stage 1
    logic             r_v1;
    logic             r_s1_mul;
    logic [WordW-1:0] r_s1_a, r_s1_b;
    logic [WordW-1:0] r_s1_ll, r_s1_hl, r_s1_lh, r_s1_hh;
    // stage 2
    logic             r_v2;
    logic             r_s2_mul;
    logic             r_s2_cy;
    logic [WordW-1:0] r_s2_hi, r_s2_lo;
    // stage 3
    logic             r_v3;
    logic [WordW-1:0] r_s3_t0, r_s3_t1;
    // stage 4 / output
    logic             r_v4;
    logic [WordW-1:0] r_s4_res;

    t_func            in_func;
    logic [WordW-1:0] in_a, in_b, in_y, in_ac;
    logic [HalfW-1:0] xl, xh, yl, yh;
    logic             in_mul;

    logic [WordW-1:0] n_s2_hi, n_s2_lo, mid, mid2;
    logic [WordW:0]   sum65;
    logic [WordW-1:0] n_s3_t0, n_s3_t1, diff;
    logic [HalfW-1:0] top, hlo;
    logic [WordW:0]   s65;
    logic [WordW-1:0] n_s4_res;

    assign en4 = !r_v4 || i_m_tready;
    assign en3 = !r_v3 || en4;
    assign en2 = !r_v2 || en3;
    assign en1 = !r_v1 || en2;
    assign o_s_tready = en1;
    assign o_m_tvalid = r_v4;
    assign o_m_tdata  = r_s4_res;

    always_comb begin
        in_func = t_func'(i_s_tuser);
        in_a    = i_s_tdata[WordW-1:0];
        in_b    = i_s_tdata[SDataW-1:WordW];
        in_mul  = (in_func == FUNC_MUL) || (in_func == FUNC_SQR);
        in_y    = (in_func == FUNC_SQR) ? in_a : in_b;
        in_ac   = (in_a >= FieldP) ? (in_a - FieldP) : in_a;
        xl      = in_a[HalfW-1:0];
        xh      = in_a[WordW-1:HalfW];
        yl      = in_y[HalfW-1:0];
        yh      = in_y[WordW-1:HalfW];
    end

    // product assembly or plain add
    always_comb begin
        mid   = r_s1_hl + {{HalfW{1'b0}}, r_s1_ll[WordW-1:HalfW]};
        mid2  = r_s1_lh + {{HalfW{1'b0}}, mid[HalfW-1:0]};
        sum65 = {1'b0, r_s1_a} + {1'b0, r_s1_b};
        if (r_s1_mul) begin
            n_s2_lo = {mid2[HalfW-1:0], r_s1_ll[HalfW-1:0]};
            n_s2_hi = r_s1_hh + {{HalfW{1'b0}}, mid[WordW-1:HalfW]}
                              + {{HalfW{1'b0}}, mid2[WordW-1:HalfW]};
        end else begin
            n_s2_lo = sum65[WordW-1:0];
            n_s2_hi = '0;
        end
    end

    // first fold step: lo - hi[63:32], and hi[31:0] * (2^32-1) for products; carry fold for add
    always_comb begin
        top  = r_s2_hi[WordW-1:HalfW];
        hlo  = r_s2_hi[HalfW-1:0];
        diff = r_s2_lo - {{HalfW{1'b0}}, top};
        if (r_s2_mul) begin
            n_s3_t0 = (r_s2_lo < {{HalfW{1'b0}}, top}) ? (diff - FieldEps) : diff;
            n_s3_t1 = {hlo, {HalfW{1'b0}}} - {{HalfW{1'b0}}, hlo};
        end else begin
            n_s3_t0 = r_s2_cy ? (r_s2_lo + FieldEps) : r_s2_lo;
            n_s3_t1 = '0;
        end
    end

    // final fold step
    always_comb begin
        s65      = {1'b0, r_s3_t0} + {1'b0, r_s3_t1};
        n_s4_res = s65[WordW] ? (s65[WordW-1:0] + FieldEps) : s65[WordW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (en1) begin
                r_v1 <= i_s_tvalid;
            end
            if (en2) begin
                r_v2 <= r_v1;
            end
            if (en3) begin
                r_v3 <= r_v2;
            end
            if (en4) begin
                r_v4 <= r_v3;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_s1_mul <= in_mul;
            r_s1_a   <= in_ac;
            r_s1_b   <= (in_func == FUNC_ADD) ? in_b : '0;
            r_s1_ll  <= {{HalfW{1'b0}}, xl} * {{HalfW{1'b0}}, yl};
            r_s1_hl  <= {{HalfW{1'b0}}, xh} * {{HalfW{1'b0}}, yl};
            r_s1_lh  <= {{HalfW{1'b0}}, xl} * {{HalfW{1'b0}}, yh};
            r_s1_hh  <= {{HalfW{1'b0}}, xh} * {{HalfW{1'b0}}, yh};
        end
        if (en2) begin
            r_s2_mul <= r_s1_mul;
            r_s2_cy  <= sum65[WordW];
            r_s2_hi  <= n_s2_hi;
            r_s2_lo  <= n_s2_lo;
        end
        if (en3) begin
            r_s3_t0 <= n_s3_t0;
            r_s3_t1 <= n_s3_t1;
        end
        if (en4) begin
            r_s4_res <= n_s4_res;
        end
    end

endmodule
